// ===== hw/rtl/wc2_pkg.sv =====
// Shared constants, types and kernel helper functions for the 3x3 window convolution.
// No dependencies; every other file of the block but wc2_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package wc2_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int KERNEL_MAX   = 3;
   localparam int WIN          = 3;
   localparam int WIN_TAPS     = WIN * WIN;
   localparam int KMAX         = (KERNEL_MAX < WIN) ? KERNEL_MAX : WIN;

   localparam int PIXEL_W      = 8;
   localparam int COEFF_W      = 7;
   localparam int PROD_W       = COEFF_W + PIXEL_W + 1;
   localparam int CONV_W       = 19;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int KSIZE_W      = 2;
   localparam int COEFFS_W     = 63;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int LINE_W       = 2 * PIXEL_W;

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 63;

   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);
   localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_KERNEL_ROWS   = 3'd2,
      CSR_KERNEL_COLS   = 3'd3,
      CSR_KERNEL_COEFFS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0]  image_width;
      logic [HEIGHT_REG_W-1:0] image_height;
      logic [KSIZE_W-1:0]      kernel_rows;
      logic [KSIZE_W-1:0]      kernel_cols;
      logic [COEFFS_W-1:0]     kernel_coeffs;
   } csr_type;

   // tap index is row*WIN + col; row 0 is the oldest line, col WIN-1 the newest pixel
   typedef logic [WIN_TAPS-1:0][PIXEL_W-1:0] window_type;

   typedef struct packed {
      window_type pixels;
      logic       window_valid;
      logic       end_of_frame;
   } work_type;

   // zero size acts as one, oversized saturates
   function automatic logic [KSIZE_W-1:0] ksize_eff(input logic [KSIZE_W-1:0] k);
      logic [KSIZE_W-1:0] res;
      if (k == '0) begin
         res = KSIZE_W'(1);
      end else if ({1'b0, k} > (KSIZE_W+1)'(KMAX)) begin
         res = KSIZE_W'(KMAX);
      end else begin
         res = k;
      end
      return res;
   endfunction

   function automatic logic tap_used(input logic [KSIZE_W-1:0] kr, input logic [KSIZE_W-1:0] kc,
                                     input logic [1:0] r, input logic [1:0] c);
      logic row_ok;
      logic col_ok;
      row_ok = ({2'b0, r} + {2'b0, kr}) >= 4'(WIN);
      col_ok = ({2'b0, c} + {2'b0, kc}) >= 4'(WIN);
      return row_ok && col_ok;
   endfunction

   // coefficient for window tap (r, c): kernel is row-major with kc entries per row
   function automatic logic signed [COEFF_W-1:0] tap_coeff(
      input logic [COEFFS_W-1:0] coeffs,
      input logic [KSIZE_W-1:0]  kr,
      input logic [KSIZE_W-1:0]  kc,
      input logic [1:0]          r,
      input logic [1:0]          c);
      logic [3:0]                i;
      logic [3:0]                j;
      logic [3:0]                k;
      logic signed [COEFF_W-1:0] res;
      i = {2'b0, r} + {2'b0, kr} - 4'(WIN);
      j = {2'b0, c} + {2'b0, kc} - 4'(WIN);
      k = 4'(i * {2'b0, kc}) + j;
      case (k)
         4'd0:    res = coeffs[0*COEFF_W +: COEFF_W];
         4'd1:    res = coeffs[1*COEFF_W +: COEFF_W];
         4'd2:    res = coeffs[2*COEFF_W +: COEFF_W];
         4'd3:    res = coeffs[3*COEFF_W +: COEFF_W];
         4'd4:    res = coeffs[4*COEFF_W +: COEFF_W];
         4'd5:    res = coeffs[5*COEFF_W +: COEFF_W];
         4'd6:    res = coeffs[6*COEFF_W +: COEFF_W];
         4'd7:    res = coeffs[7*COEFF_W +: COEFF_W];
         4'd8:    res = coeffs[8*COEFF_W +: COEFF_W];
         default: res = '0;
      endcase
      if (!tap_used(kr, kc, r, c)) begin
         res = '0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wc2_queue.sv =====
// Short work queue between the convolution front end and the multiply-add back end.
// Depends on wc2_pkg for the work item type and queue depth.
`timescale 1ns / 1ps
`default_nettype none

module wc2_queue
   import wc2_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire work_type           push_data,
   input  wire logic               pop,
   output      work_type           pop_data,
   output      logic               not_empty,
   output      logic [Q_CNT_W-1:0] level
);

   work_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign level     = count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wc2_front.sv =====
// Front end: takes pixels, keeps raster position, line store and the window register,
// and pushes one classified window per pixel into the work queue. Depends on wc2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wc2_front
   import wc2_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csr_type            csr,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic [Q_CNT_W-1:0] q_level,
   output      logic               push,
   output      work_type           push_data
);

   // line store entry: [15:8] row r-2, [7:0] row r-1
   logic [LINE_W-1:0]  line_mem [MAX_WIDTH];

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               f1_v_ff;
   logic [COL_W-1:0]   f1_col_ff;
   logic [PIXEL_W-1:0] f1_px_ff;
   logic               f1_valid_ff;
   logic               f1_eof_ff;
   logic [LINE_W-1:0]  rd_ff;
   logic               byp_ff;
   logic [LINE_W-1:0]  byp_data_ff;
   window_type         win_ff, win_in;

   logic                    accept;
   logic [WIDTH_REG_W-1:0]  w_eff;
   logic [HEIGHT_REG_W-1:0] h_eff;
   logic [KSIZE_W-1:0]      kr_eff;
   logic [KSIZE_W-1:0]      kc_eff;
   logic                    last_col;
   logic                    last_row;
   logic                    win_valid;
   logic [LINE_W-1:0]       line_rd;
   logic [LINE_W-1:0]       line_wr;
   logic [Q_CNT_W:0]        in_flight;

   assign in_flight = {1'b0, q_level} + (Q_CNT_W+1)'(f1_v_ff);
   assign req_ready = in_flight < (Q_CNT_W+1)'(Q_DEPTH);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (csr.image_width == '0) begin
         w_eff = WIDTH_REG_W'(1);
      end else if (csr.image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_REG_W'(MAX_WIDTH);
      end else begin
         w_eff = csr.image_width;
      end
      if (csr.image_height == '0) begin
         h_eff = HEIGHT_REG_W'(1);
      end else if (csr.image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         h_eff = csr.image_height;
      end
      kr_eff    = ksize_eff(csr.kernel_rows);
      kc_eff    = ksize_eff(csr.kernel_cols);
      last_col  = (WIDTH_REG_W'(col_ff) + WIDTH_REG_W'(1)) >= w_eff;
      last_row  = (HEIGHT_REG_W'(row_ff) + HEIGHT_REG_W'(1)) >= h_eff;
      win_valid = (row_ff >= ROW_W'(kr_eff - KSIZE_W'(1)))
               && (col_ff >= COL_W'(kc_eff - KSIZE_W'(1)));

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // the previous pixel may have written the entry this one read
   assign line_rd = byp_ff ? byp_data_ff : rd_ff;
   assign line_wr = {line_rd[PIXEL_W-1:0], f1_px_ff};

   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < WIN; r++) begin
         for (int c = 0; c < WIN - 1; c++) begin
            win_in[r*WIN + c] = win_ff[r*WIN + c + 1];
         end
      end
      win_in[0*WIN + WIN - 1] = line_rd[LINE_W-1:PIXEL_W];
      win_in[1*WIN + WIN - 1] = line_rd[PIXEL_W-1:0];
      win_in[2*WIN + WIN - 1] = f1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         f1_v_ff <= 1'b0;
         byp_ff  <= 1'b0;
         win_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         f1_v_ff <= accept;
         byp_ff  <= accept && f1_v_ff && (col_ff == f1_col_ff);
         if (f1_v_ff) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= line_wr;
      if (accept) begin
         f1_col_ff   <= col_ff;
         f1_px_ff    <= req_pixel;
         f1_valid_ff <= win_valid;
         f1_eof_ff   <= last_col && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (f1_v_ff) begin
         line_mem[f1_col_ff] <= line_wr;
      end
   end

   assign push                   = f1_v_ff;
   assign push_data.pixels       = win_in;
   assign push_data.window_valid = f1_valid_ff;
   assign push_data.end_of_frame = f1_eof_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wc2_back.sv =====
// Back end: nine parallel pixel-by-coefficient products, then the sum into the result
// register. Pops work items from the queue. Depends on wc2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wc2_back
   import wc2_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire csr_type                  csr,
   input  wire logic                     q_not_empty,
   input  wire work_type                 q_data,
   output      logic                     q_pop,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [CONV_W-1:0] rsp_conv_value,
   output      logic                     rsp_window_valid,
   output      logic                     rsp_end_of_frame
);

   logic signed [PROD_W-1:0] prod_ff [WIN_TAPS];
   logic signed [PROD_W-1:0] prod_in [WIN_TAPS];
   logic                     m_v_ff;
   logic                     m_valid_ff;
   logic                     m_eof_ff;
   logic                     out_v_ff;
   logic signed [CONV_W-1:0] conv_ff, conv_in;
   logic                     valid_ff;
   logic                     eof_ff;

   logic               out_ready;
   logic               m_ready;
   logic [KSIZE_W-1:0] kr_eff;
   logic [KSIZE_W-1:0] kc_eff;

   assign kr_eff    = ksize_eff(csr.kernel_rows);
   assign kc_eff    = ksize_eff(csr.kernel_cols);
   assign out_ready = !out_v_ff || rsp_ready;
   assign m_ready   = !m_v_ff || out_ready;
   assign q_pop     = q_not_empty && m_ready;

   // taps outside the kernel, and whole invalid windows, contribute zero
   always_comb begin
      logic [PIXEL_W-1:0] pix;
      logic               keep;
      for (int r = 0; r < WIN; r++) begin
         for (int c = 0; c < WIN; c++) begin
            keep = q_data.window_valid && tap_used(kr_eff, kc_eff, 2'(r), 2'(c));
            pix  = keep ? q_data.pixels[r*WIN + c] : '0;
            prod_in[r*WIN + c] = tap_coeff(csr.kernel_coeffs, kr_eff, kc_eff, 2'(r), 2'(c))
                               * $signed({1'b0, pix});
         end
      end
   end

   always_comb begin
      conv_in = '0;
      for (int t = 0; t < WIN_TAPS; t++) begin
         conv_in = conv_in + CONV_W'(prod_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_v_ff <= q_pop;
         end
         if (out_ready) begin
            out_v_ff <= m_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff    <= prod_in;
         m_valid_ff <= q_data.window_valid;
         m_eof_ff   <= q_data.end_of_frame;
      end
      if (out_ready && m_v_ff) begin
         conv_ff  <= conv_in;
         valid_ff <= m_valid_ff;
         eof_ff   <= m_eof_ff;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_conv_value   = conv_ff;
   assign rsp_window_valid = valid_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/window_convolution_2d_top.sv =====
// Top level of the 3x3 window convolution: configuration registers, front end, queue
// and back end. Depends on wc2_pkg, wc2_front, wc2_queue and wc2_back.
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2D convolution with a kernel of up to 3x3 signed 7-bit coefficients over
// 8-bit pixels in raster order. Every request yields exactly one response: the exact
// sum of products over the window whose bottom-right corner is that pixel (no kernel
// flip, no rounding), window_valid set only where the whole window is inside the frame
// and the value forced to zero otherwise, and end_of_frame on the last pixel of a frame.
// Centering the output is up to the consumer. The block sustains one request per clock
// while the response side does not stall; each request passes the front-end register,
// the queue, the product and the result register before rsp_valid rises. The front end
// reads and rewrites one line store entry per pixel (a 1024 x 16 memory, one read and one
// write port), which sets the one-per-clock pace; a four-entry queue lets the front keep
// taking requests while the response side stalls. The line store is never cleared: its
// content before the first rows are written only feeds windows flagged invalid. Write
// configuration through csr_we/csr_index/csr_wdata only while no request is in flight;
// the raster position is kept across writes, so a smaller width or height simply ends
// the current row or frame early.
module window_convolution_2d_top
   import wc2_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [PIXEL_W-1:0]       req_pixel,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [CONV_W-1:0] rsp_conv_value,
   output      logic                     rsp_window_valid,
   output      logic                     rsp_end_of_frame,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   csr_type            csr_ff;
   logic               push;
   work_type           push_data;
   logic               pop;
   work_type           pop_data;
   logic               q_not_empty;
   logic [Q_CNT_W-1:0] q_level;

   // Hold configuration; unknown indexes drop the write.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.image_width   <= WIDTH_REG_W'(640);
         csr_ff.image_height  <= HEIGHT_REG_W'(480);
         csr_ff.kernel_rows   <= KSIZE_W'(3);
         csr_ff.kernel_cols   <= KSIZE_W'(3);
         csr_ff.kernel_coeffs <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   csr_ff.image_width   <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT:  csr_ff.image_height  <= csr_wdata[HEIGHT_REG_W-1:0];
            CSR_KERNEL_ROWS:   csr_ff.kernel_rows   <= csr_wdata[KSIZE_W-1:0];
            CSR_KERNEL_COLS:   csr_ff.kernel_cols   <= csr_wdata[KSIZE_W-1:0];
            CSR_KERNEL_COEFFS: csr_ff.kernel_coeffs <= csr_wdata[COEFFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Front: track raster position, shift the window, classify.
   wc2_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .q_level   (q_level),
      .push      (push),
      .push_data (push_data)
   );

   // Queue: decouple the response stall from the request side.
   wc2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty),
      .level     (q_level)
   );

   // Back: multiply, sum, register the response.
   wc2_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr              (csr_ff),
      .q_not_empty      (q_not_empty),
      .q_data           (pop_data),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_conv_value   (rsp_conv_value),
      .rsp_window_valid (rsp_window_valid),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/wc2_checker.sv =====
// Port-level checks for the window convolution, bound to the top level.
// Depends only on the top-level port list.
`timescale 1ns / 1ps
`default_nettype none

module wc2_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [18:0] rsp_conv_value,
   input wire logic        rsp_window_valid,
   input wire logic        rsp_end_of_frame
);

   logic [3:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 4'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_conv_value)
         && $stable(rsp_window_valid) && $stable(rsp_end_of_frame))
      else $error("response changed while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_valid |-> rsp_conv_value == 19'd0)
      else $error("invalid window with nonzero value");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("response without a pending request");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind window_convolution_2d_top wc2_checker u_wc2_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_conv_value   (rsp_conv_value),
   .rsp_window_valid (rsp_window_valid),
   .rsp_end_of_frame (rsp_end_of_frame)
);

`default_nettype wire
